// File: hw/rtl/asif_pkg.sv
`default_nettype none

package asif_pkg;

    localparam int unsigned MS_W    = 16;
    localparam int unsigned CNT_W   = 8;
    localparam int unsigned LQ_W    = 8;
    localparam int unsigned STATE_W = 3;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_TIMEOUT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_DEBOUNCE     = 8'd1;

    localparam logic [MS_W-1:0]  RST_FAILSAFE_TIMEOUT = 16'd500;
    localparam logic [CNT_W-1:0] RST_ARM_DEBOUNCE     = 8'd5;

    // arm state codes as seen on the output
    localparam logic [STATE_W-1:0] ST_BOOT     = 3'd0;
    localparam logic [STATE_W-1:0] ST_DISARMED = 3'd1;
    localparam logic [STATE_W-1:0] ST_ARMED    = 3'd2;
    localparam logic [STATE_W-1:0] ST_FAILSAFE = 3'd3;
    localparam logic [STATE_W-1:0] ST_ERROR    = 3'd4;

    typedef struct packed {
        logic            frame_valid;
        logic            switch_seen_low;
        logic            spin_stick_zero;
        logic            link_healthy;
        logic            sensors_ok;
        logic            switch_high_now;
        logic [LQ_W-1:0] link_quality;
        logic            battery_present;
        logic            vbat_sane;
        logic            low_voltage_critical;
        logic            settings_valid;
        logic [MS_W-1:0] ms_since_frame;
    } t_in;

    typedef struct packed {
        logic [STATE_W-1:0] arm_state_out;
        logic [CNT_W-1:0]   debounce_count;
    } t_out;

endpackage

`default_nettype wire

// File: hw/rtl/asif_if.sv
`default_nettype none

interface asif_in_if;
    logic           valid;
    logic           ready;
    asif_pkg::t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface asif_out_if;
    logic           valid;
    logic           ready;
    asif_pkg::t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface asif_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [asif_pkg::CFG_IDX_W-1:0]      index;
    logic [asif_pkg::CFG_DAT_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/asif_fsm.sv
`default_nettype none

module asif_fsm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire asif_pkg::t_in                 i_item,
    input  wire logic [asif_pkg::MS_W-1:0]     i_timeout,
    input  wire logic [asif_pkg::CNT_W-1:0]    i_debounce,
    output asif_pkg::t_out                     o_result
);

    typedef enum logic [asif_pkg::STATE_W-1:0] {
        BOOT     = asif_pkg::ST_BOOT,
        DISARMED = asif_pkg::ST_DISARMED,
        ARMED    = asif_pkg::ST_ARMED,
        FAILSAFE = asif_pkg::ST_FAILSAFE,
        ERROR    = asif_pkg::ST_ERROR
    } t_state;

    t_state                       r_state, n_state;
    logic [asif_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                         r_batt, n_batt;

    logic                         running;
    logic                         link_lost;
    logic                         hard_fault;
    logic                         sw_low_only;
    logic [asif_pkg::CNT_W-1:0]   cnt_inc;
    logic                         arm_ok;

    assign running     = (r_state != BOOT) && (r_state != ERROR);
    assign link_lost   = (i_item.link_quality == '0) || (i_item.ms_since_frame > i_timeout);
    assign hard_fault  = i_item.low_voltage_critical || !i_item.vbat_sane
                         || !i_item.settings_valid;
    assign sw_low_only = i_item.frame_valid && i_item.switch_seen_low
                         && !i_item.switch_high_now;
    assign cnt_inc     = (r_cnt == asif_pkg::COUNT_MAX) ? r_cnt : r_cnt + 1'b1;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_batt  = r_batt;
        arm_ok  = 1'b0;
        if (running && link_lost) begin
            n_state = FAILSAFE;
            n_cnt   = '0;
        end else if (running && hard_fault) begin
            n_state = ERROR;
            n_cnt   = '0;
        end else if (r_state == ARMED && !r_batt && i_item.battery_present) begin
            // battery hot-plugged while armed
            n_state = DISARMED;
            n_cnt   = '0;
            n_batt  = i_item.battery_present;
        end else begin
            n_batt = i_item.battery_present;
            if (r_state != BOOT && !i_item.sensors_ok) begin
                n_state = ERROR;
                n_cnt   = '0;
            end else begin
                n_cnt = (i_item.frame_valid && i_item.switch_high_now) ? cnt_inc : '0;
                arm_ok = i_item.frame_valid && i_item.switch_seen_low
                         && i_item.spin_stick_zero && i_item.link_healthy
                         && i_item.sensors_ok && i_item.switch_high_now
                         && (i_item.link_quality != '0) && i_item.battery_present
                         && i_item.vbat_sane && !i_item.low_voltage_critical
                         && i_item.settings_valid && (n_cnt >= i_debounce);
                case (r_state)
                    BOOT: begin
                        n_state = sw_low_only ? DISARMED : BOOT;
                    end
                    DISARMED: begin
                        n_state = arm_ok ? ARMED : DISARMED;
                    end
                    ARMED: begin
                        if (!i_item.switch_high_now) begin
                            n_state = DISARMED;
                            n_cnt   = '0;
                        end
                    end
                    FAILSAFE: begin
                        if (i_item.link_healthy && (i_item.link_quality != '0) && sw_low_only)
                            n_state = DISARMED;
                    end
                    ERROR: begin
                        if (i_item.sensors_ok && sw_low_only)
                            n_state = DISARMED;
                    end
                    default: begin
                        n_state = ERROR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BOOT;
            r_cnt   <= '0;
            r_batt  <= 1'b0;
        end else if (i_step) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_batt  <= n_batt;
        end
    end

    assign o_result.arm_state_out  = n_state;
    assign o_result.debounce_count = n_cnt;

endmodule

`default_nettype wire

// File: hw/rtl/arming_safety_interlock_fsm_top.sv
// an accepted item is held in the input register, and its result is shown from the result register
// throughput: one item per cycle while the result register is free or being drained; the arm
// state updates once per item between the input register and the result register
// reset (synchronous, active low): arm state boot, debounce count zero,
// battery flag clear, timeout 500 ms, debounce threshold 5, both registers empty
`default_nettype none

module arming_safety_interlock_fsm_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    asif_in_if.sink      i_in,
    asif_out_if.source   o_out,
    asif_cfg_if.sink     i_cfg
);

    // configuration registers
    logic [asif_pkg::MS_W-1:0]  r_timeout;
    logic [asif_pkg::CNT_W-1:0] r_debounce;

    // input register
    logic                       r_in_vld;
    asif_pkg::t_in              r_in;

    // result register
    logic                       r_out_vld;
    asif_pkg::t_out             r_out;

    logic                       step;
    asif_pkg::t_out             result;

    // the held item moves on when the result register is free or being drained
    assign step        = r_in_vld && (!r_out_vld || o_out.ready);
    // take a new item whenever the input register empties in this cycle
    assign i_in.ready  = !r_in_vld || step;
    // writes are never held off; the user must issue them only while idle, the block does not enforce it
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= asif_pkg::RST_FAILSAFE_TIMEOUT;
            r_debounce <= asif_pkg::RST_ARM_DEBOUNCE;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                asif_pkg::REG_FAILSAFE_TIMEOUT: r_timeout  <= i_cfg.data;
                asif_pkg::REG_ARM_DEBOUNCE:     r_debounce <= i_cfg.data[asif_pkg::CNT_W-1:0];
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // arm state machine: state moves forward once per item in the input register
    asif_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_in),
        .i_timeout  (r_timeout),
        .i_debounce (r_debounce),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (!r_out_vld || o_out.ready) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/asif_chk.sv
`default_nettype none

module asif_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_ready,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic [asif_pkg::STATE_W-1:0]     i_out_state,
    input wire logic [asif_pkg::CNT_W-1:0]       i_out_count
);

    logic [asif_pkg::STATE_W-1:0] r_last_state;
    logic                         out_acc;

    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_state <= asif_pkg::ST_BOOT;
        end else if (out_acc) begin
            r_last_state <= i_out_state;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_state)
        && $stable(i_out_count))
        else $error("result changed while stalled");

    // input side only stalls behind a full result register
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled with result side free");

    // armed is only reached from disarmed
    a_arm_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && i_out_state == asif_pkg::ST_ARMED
        |-> r_last_state == asif_pkg::ST_DISARMED || r_last_state == asif_pkg::ST_ARMED)
        else $error("armed without passing through disarmed");

    // boot only leaves to disarmed
    a_boot_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_last_state == asif_pkg::ST_BOOT
        |-> i_out_state == asif_pkg::ST_BOOT || i_out_state == asif_pkg::ST_DISARMED)
        else $error("illegal exit from boot");

endmodule

bind arming_safety_interlock_fsm_top asif_chk u_asif_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_state (o_out.data.arm_state_out),
    .i_out_count (o_out.data.debounce_count)
);

`default_nettype wire

// File: tb/sv/arming_safety_interlock_fsm_top_tb.sv
module arming_safety_interlock_fsm_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asif_pkg::*;

    // run stops here no matter what; a correct run needs a small fraction of it
    localparam int unsigned CYCLE_LIMIT = 400000;
    // hold-off of the result side used to back the block up into its input
    localparam int unsigned LONG_HOLD = 80;
    // unused register index, the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
    // only this many mismatches are printed, all of them are counted
    localparam int unsigned MAX_REPORTS = 50;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    asif_in_if  in_if ();
    asif_out_if out_if ();
    asif_cfg_if cfg_if ();

    arming_safety_interlock_fsm_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // interlock predictor: own copy of the arm state, debounce count,
    // battery flag and both registers, advanced once per accepted item
    // ------------------------------------------------------------------
    logic [STATE_W-1:0] arm_st       = ST_BOOT;
    logic [CNT_W-1:0]   debounce_cnt = '0;
    logic               batt_seen    = 1'b0;
    logic [MS_W-1:0]    fs_timeout   = RST_FAILSAFE_TIMEOUT;
    logic [CNT_W-1:0]   arm_frames   = RST_ARM_DEBOUNCE;

    function automatic t_out interlock_next(input t_in f);
        logic running;
        t_out r;
        running = (arm_st != ST_BOOT) && (arm_st != ST_ERROR);
        if (running && (f.link_quality == '0 || f.ms_since_frame > fs_timeout)) begin
            // link loss: failsafe, battery flag untouched
            debounce_cnt = '0;
            arm_st = ST_FAILSAFE;
        end else if (running && (f.low_voltage_critical || !f.vbat_sane ||
                                 !f.settings_valid)) begin
            // hard fault, battery flag untouched
            debounce_cnt = '0;
            arm_st = ST_ERROR;
        end else if (arm_st == ST_ARMED && !batt_seen && f.battery_present) begin
            // battery plugged in while armed
            debounce_cnt = '0;
            batt_seen = 1'b1;
            arm_st = ST_DISARMED;
        end else begin
            batt_seen = f.battery_present;
            if (arm_st != ST_BOOT && !f.sensors_ok) begin
                debounce_cnt = '0;
                arm_st = ST_ERROR;
            end else begin
                // debounce count saturates at the top
                if (f.frame_valid && f.switch_high_now) begin
                    if (debounce_cnt != COUNT_MAX)
                        debounce_cnt = debounce_cnt + 1'b1;
                end else begin
                    debounce_cnt = '0;
                end
                case (arm_st)
                    ST_BOOT: begin
                        if (f.frame_valid && f.switch_seen_low && !f.switch_high_now)
                            arm_st = ST_DISARMED;
                    end
                    ST_DISARMED: begin
                        if (f.frame_valid && f.switch_seen_low && f.spin_stick_zero &&
                            f.link_healthy && f.sensors_ok && f.switch_high_now &&
                            f.link_quality != '0 && f.battery_present && f.vbat_sane &&
                            !f.low_voltage_critical && f.settings_valid &&
                            debounce_cnt >= arm_frames)
                            arm_st = ST_ARMED;
                    end
                    ST_ARMED: begin
                        // switch low disarms at once
                        if (!f.switch_high_now) begin
                            debounce_cnt = '0;
                            arm_st = ST_DISARMED;
                        end
                    end
                    ST_FAILSAFE: begin
                        if (f.link_healthy && f.link_quality != '0 && f.frame_valid &&
                            f.switch_seen_low && !f.switch_high_now)
                            arm_st = ST_DISARMED;
                    end
                    ST_ERROR: begin
                        if (f.sensors_ok && f.frame_valid && f.switch_seen_low &&
                            !f.switch_high_now)
                            arm_st = ST_DISARMED;
                    end
                    default: arm_st = ST_ERROR;
                endcase
            end
        end
        r.arm_state_out  = arm_st;
        r.debounce_count = debounce_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // frame builders
    // ------------------------------------------------------------------
    t_in  frames_pending[$];   // items not yet accepted by the block
    t_out status_due[$];       // predicted state/count, oldest first
    int unsigned frames_queued = 0;
    int unsigned errs = 0;

    // every precondition met, link fresh within the current timeout
    function automatic t_in clean_frame(input logic hi);
        t_in f;
        f.frame_valid          = 1'b1;
        f.switch_seen_low      = 1'b1;
        f.spin_stick_zero      = 1'b1;
        f.link_healthy         = 1'b1;
        f.sensors_ok           = 1'b1;
        f.switch_high_now      = hi;
        f.link_quality         = LQ_W'($urandom_range(255, 1));
        f.battery_present      = 1'b1;
        f.vbat_sane            = 1'b1;
        f.low_voltage_critical = 1'b0;
        f.settings_valid       = 1'b1;
        f.ms_since_frame       = MS_W'($urandom_range(fs_timeout, 0));
        return f;
    endfunction

    function automatic t_in noise_frame();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_in)-1:0];
    endfunction

    task automatic put(input t_in f);
        frames_pending.push_back(f);
        frames_queued++;
    endtask

    // one precondition broken while the switch asks to arm
    function automatic t_in spoiled_frame();
        t_in f;
        f = clean_frame(1'b1);
        case ($urandom_range(5))
            0: f.spin_stick_zero = 1'b0;
            1: f.link_healthy = 1'b0;
            2: f.frame_valid = 1'b0;
            3: f.switch_seen_low = 1'b0;
            4: f.battery_present = 1'b0;
            default: f.sensors_ok = 1'b0;
        endcase
        return f;
    endfunction

    // a fault or disturbance, then one frame that tries to recover
    task automatic add_fault();
        t_in f;
        f = clean_frame(1'b1);
        case ($urandom_range(8))
            0: f.link_quality = '0;
            1: begin
                if (fs_timeout != 16'hFFFF)
                    f.ms_since_frame = MS_W'($urandom_range(16'hFFFF, fs_timeout + 1));
                else
                    f.link_quality = '0;
            end
            2: f.low_voltage_critical = 1'b1;
            3: f.vbat_sane = 1'b0;
            4: f.settings_valid = 1'b0;
            5: f.sensors_ok = 1'b0;
            6: begin
                // battery drops out and comes back
                f.battery_present = 1'b0;
                put(f);
                f = clean_frame(1'b1);
            end
            7: f = noise_frame();
            default: f = spoiled_frame();
        endcase
        put(f);
        put(clean_frame(1'b0));
    endtask

    // disarm, hold the switch high for a while, maybe a fault, switch low
    task automatic add_arm_cycle(input int highs);
        int k;
        put(clean_frame(1'b0));
        put(clean_frame(1'b0));
        for (k = 0; k < highs; k++)
            put(clean_frame(1'b1));
        if ($urandom_range(1))
            add_fault();
        put(clean_frame(1'b0));
    endtask

    task automatic add_random(input int unsigned n);
        int unsigned start;
        int unsigned pick;
        int k;
        start = frames_queued;
        while (frames_queued - start < n) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // mostly reach the threshold, sometimes stop short of it
                if ($urandom_range(3) == 0)
                    add_arm_cycle($urandom_range(arm_frames, 0));
                else
                    add_arm_cycle(int'(arm_frames) + $urandom_range(3, 0));
            end else if (pick < 60) begin
                add_fault();
            end else if (pick < 75) begin
                for (k = $urandom_range(4, 1); k > 0; k--)
                    put(spoiled_frame());
            end else begin
                put(noise_frame());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // configuration writes, only issued with the block idle
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge i_clk);
        while (!cfg_if.ready);
        if (idx == REG_FAILSAFE_TIMEOUT)
            fs_timeout = val;
        else if (idx == REG_ARM_DEBOUNCE)
            arm_frames = val[CNT_W-1:0];
        cfg_if.valid <= 1'b0;
    endtask

    // sender stops until every predicted result has come back
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (frames_pending.size() != 0 || status_due.size() != 0 || in_if.valid);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                void'(frames_pending.pop_front());
            // hold an offered item until it is taken
            if (!in_if.valid || in_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (frames_pending.size() != 0) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= frames_pending[0];
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // long bursts give stretches with no gaps at all
                        burst_left = ($urandom_range(4) == 0) ? $urandom_range(150, 40)
                                                              : $urandom_range(12, 1);
                        gap_left = ($urandom_range(5) == 0) ? $urandom_range(30, 6)
                                                            : $urandom_range(4, 0);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern of its own, plus a long hold-off on request
    // ------------------------------------------------------------------
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned rx_mode = 0;
    int unsigned rx_mode_left = 0;

    always @(posedge i_clk) begin
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(3);
                rx_mode_left = $urandom_range(200, 20);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= 1'($urandom_range(1));
                2: out_if.ready <= ($urandom_range(4) != 0);
                default: out_if.ready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor: predict on input accept, compare on output accept
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                status_due.push_back(interlock_next(in_if.data));
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (status_due.size() == 0) begin
                    if (errs < MAX_REPORTS)
                        $error("unexpected result: arm_state_out %0d debounce_count %0d",
                               got.arm_state_out, got.debounce_count);
                    errs++;
                end else begin
                    want = status_due.pop_front();
                    if (got.arm_state_out !== want.arm_state_out) begin
                        if (errs < MAX_REPORTS)
                            $error("arm_state_out: expected %0d, actual %0d",
                                   want.arm_state_out, got.arm_state_out);
                        errs++;
                    end
                    if (got.debounce_count !== want.debounce_count) begin
                        if (errs < MAX_REPORTS)
                            $error("debounce_count: expected %0d, actual %0d",
                                   want.debounce_count, got.debounce_count);
                        errs++;
                    end
                end
            end
        end
    end

    // hard stop for a hung handshake
    int unsigned cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_in f;
        int k;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk at reset register values (timeout 500, threshold 5)
        f = clean_frame(1'b1);
        f.frame_valid = 1'b0;
        put(f);                                  // boot ignores a stale frame
        f = clean_frame(1'b0);
        f.switch_seen_low = 1'b0;
        put(f);                                  // boot needs switch seen low
        put(clean_frame(1'b0));                  // boot to disarmed
        for (k = 0; k < 5; k++) begin
            f = clean_frame(1'b1);
            f.link_quality = 8'hFF;
            f.ms_since_frame = 16'd500;          // at the timeout, not past it
            put(f);                              // arms on the fifth frame
        end
        f = clean_frame(1'b1);
        f.ms_since_frame = 16'd501;
        put(f);                                  // one past timeout: failsafe
        put(clean_frame(1'b0));                  // failsafe recovers
        for (k = 0; k < 2; k++) begin
            f = clean_frame(1'b1);
            f.link_healthy = 1'b0;
            f.link_quality = 8'd1;
            put(f);                              // counts but cannot arm
        end
        f = clean_frame(1'b1);
        f.low_voltage_critical = 1'b1;
        put(f);                                  // hard fault: error
        f = clean_frame(1'b0);
        f.sensors_ok = 1'b0;
        put(f);                                  // error holds on sensor fault
        put(clean_frame(1'b0));                  // error recovers
        f = clean_frame(1'b1);
        f.sensors_ok = 1'b0;
        put(f);                                  // sensor fault from disarmed
        put(clean_frame(1'b0));
        for (k = 0; k < 5; k++)
            put(clean_frame(1'b1));              // arm again
        f = clean_frame(1'b1);
        f.battery_present = 1'b0;
        put(f);                                  // armed, battery flag drops
        put(clean_frame(1'b1));                  // battery back: hot-plug disarm
        f = clean_frame(1'b1);
        f.link_quality = '0;
        put(f);                                  // no packets: failsafe
        f = clean_frame(1'b0);
        f.ms_since_frame = 16'hFFFF;
        put(f);                                  // stays failsafe at max age
        put(clean_frame(1'b0));

        add_random(250);
        wait_idle();

        // lowest settings: any nonzero frame age trips failsafe, arming on first frame
        write_reg(REG_FAILSAFE_TIMEOUT, '0);
        write_reg(REG_ARM_DEBOUNCE, '0);
        add_random(300);
        wait_idle();

        // highest settings: age never trips, the count must saturate
        write_reg(REG_FAILSAFE_TIMEOUT, 16'hFFFF);
        write_reg(REG_ARM_DEBOUNCE, 16'h00FF);
        add_arm_cycle(262);
        add_random(140);
        wait_idle();

        // mid settings, a write to the unused index, and a long result hold-off
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_FAILSAFE_TIMEOUT, 16'($urandom_range(3000, 100)));
        write_reg(REG_ARM_DEBOUNCE, 16'($urandom_range(12, 1)));
        add_random(500);
        @(negedge i_clk);
        hold_asked++;
        wait_idle();

        // back to the reset values
        write_reg(REG_FAILSAFE_TIMEOUT, RST_FAILSAFE_TIMEOUT);
        write_reg(REG_ARM_DEBOUNCE, 16'(RST_ARM_DEBOUNCE));
        add_random(450);

        do
            @(negedge i_clk);
        while (frames_pending.size() != 0 || status_due.size() != 0);
        repeat (10) @(posedge i_clk);

        if (status_due.size() != 0) begin
            $error("%0d results never arrived", status_due.size());
            errs++;
        end
        if (errs == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
